### design/wmd_pkg.sv
// ----------------------------------------------------------------------------
// wmd_pkg
// Shared types and constants for the min/max waveform decimator.
// ----------------------------------------------------------------------------
package wmd_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int SPC_W    = 24;
  localparam int SCAN_W   = 16;
  localparam int COL_W    = 10;
  localparam int HIGH_W   = 15;
  localparam int UPPER_W  = 7;
  localparam int LOWER_W  = 8;
  localparam int PROD_W   = 31;

  // divide by 300 as multiply by reciprocal and shift (exact for 0..32768)
  localparam logic [15:0] DIV_RECIP = 16'd55925;
  localparam int          DIV_SHIFT = 24;

  // column queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // register indexes
  localparam logic REG_SPC = 1'b0;

  // finished column, raw peaks before scaling
  typedef struct packed {
    logic [HIGH_W-1:0]   high;
    logic [SAMPLE_W-1:0] low_mag;
    logic [COL_W-1:0]    column;
    logic                last;
  } col_rec_t;

endpackage

### design/wmd_front.sv
// ----------------------------------------------------------------------------
// wmd_front
// Accepts samples, tracks column position and running peaks, and pushes one
// record per finished column into the queue.
// ----------------------------------------------------------------------------
module wmd_front #(
  parameter int COLUMNS = 600
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [wmd_pkg::SAMPLE_W-1:0] sample,
  input  logic                          frame_start,
  input  logic [wmd_pkg::SPC_W-1:0]     span,
  input  logic [wmd_pkg::SCAN_W-1:0]    scan,
  output logic                          push_valid,
  input  logic                          push_ready,
  output wmd_pkg::col_rec_t             push_data
);
  import wmd_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

  logic [SPC_W-1:0]           pos_r, pos_nxt;
  logic [COL_W-1:0]           col_r, col_nxt;
  logic [HIGH_W-1:0]          high_r, high_nxt;
  logic signed [SAMPLE_W-1:0] low_r, low_nxt;
  logic                       done_r, done_nxt;

  logic                       accept;
  logic [SPC_W-1:0]           pos_b, pos_inc;
  logic [COL_W-1:0]           col_b;
  logic [HIGH_W-1:0]          high_b, high_upd;
  logic signed [SAMPLE_W-1:0] low_b, low_upd;
  logic                       in_scan, col_end, is_last, active;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // base state, cleared by a frame start
  always_comb begin
    pos_b  = frame_start ? '0 : pos_r;
    col_b  = frame_start ? '0 : col_r;
    high_b = frame_start ? '0 : high_r;
    low_b  = frame_start ? '0 : low_r;
  end

  // peak update within the scanned part of the column
  always_comb begin
    active   = frame_start || !done_r;
    in_scan  = pos_b < SPC_W'(scan);
    high_upd = high_b;
    low_upd  = low_b;
    if (in_scan) begin
      if (!sample[SAMPLE_W-1] && (sample[HIGH_W-1:0] > high_b)) begin
        high_upd = sample[HIGH_W-1:0];
      end
      if (sample < low_b) begin
        low_upd = sample;
      end
    end
    pos_inc = pos_b + SPC_W'(1);
    col_end = pos_inc >= span;
    is_last = col_b == LAST_COL;
  end

  // next state
  always_comb begin
    pos_nxt  = pos_r;
    col_nxt  = col_r;
    high_nxt = high_r;
    low_nxt  = low_r;
    done_nxt = done_r;
    if (accept && active) begin
      done_nxt = 1'b0;
      if (col_end) begin
        pos_nxt  = '0;
        high_nxt = '0;
        low_nxt  = '0;
        if (is_last) begin
          done_nxt = 1'b1;
          col_nxt  = '0;
        end else begin
          col_nxt = col_b + COL_W'(1);
        end
      end else begin
        pos_nxt  = pos_inc;
        col_nxt  = col_b;
        high_nxt = high_upd;
        low_nxt  = low_upd;
      end
    end
  end

  // column record towards the queue
  always_comb begin
    push_valid        = accept && active && col_end;
    push_data.high    = high_upd;
    push_data.low_mag = SAMPLE_W'(0) - low_upd;
    push_data.column  = col_b;
    push_data.last    = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      col_r  <= '0;
      high_r <= '0;
      low_r  <= '0;
      done_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      col_r  <= col_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

### design/wmd_queue.sv
// ----------------------------------------------------------------------------
// wmd_queue
// Short register queue of finished column records between front and back.
// ----------------------------------------------------------------------------
module wmd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  wmd_pkg::col_rec_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output wmd_pkg::col_rec_t pop_data
);
  import wmd_pkg::*;

  col_rec_t        entry_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;
  logic            do_push, do_pop;

  assign push_ready = count_r != (Q_AW+1)'(Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (Q_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (Q_AW+1)'(1);
      end
    end
  end

endmodule

### design/wmd_back.sv
// ----------------------------------------------------------------------------
// wmd_back
// Scales column peaks by 1/300 (reciprocal multiply, then shift) and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module wmd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  wmd_pkg::col_rec_t            pop_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wmd_pkg::UPPER_W-1:0]  upper_peak,
  output logic [wmd_pkg::LOWER_W-1:0]  lower_peak,
  output logic [wmd_pkg::COL_W-1:0]    column_index,
  output logic                         last_column
);
  import wmd_pkg::*;

  logic              s1_valid_r;
  logic [PROD_W-1:0] s1_up_prod_r, s1_lo_prod_r;
  logic [COL_W-1:0]  s1_col_r;
  logic              s1_last_r;

  logic               out_valid_r;
  logic [UPPER_W-1:0] out_upper_r;
  logic [LOWER_W-1:0] out_lower_r;
  logic [COL_W-1:0]   out_col_r;
  logic               out_last_r;

  logic               out_adv, s1_adv;
  logic [UPPER_W-1:0] up_q, lo_q;

  assign out_adv   = !out_valid_r || out_ready;
  assign s1_adv    = !s1_valid_r || out_adv;
  assign pop_ready = s1_adv;

  assign up_q = s1_up_prod_r[DIV_SHIFT +: UPPER_W];
  assign lo_q = s1_lo_prod_r[DIV_SHIFT +: UPPER_W];

  // multiply stage
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_up_prod_r <= PROD_W'(pop_data.high) * PROD_W'(DIV_RECIP);
      s1_lo_prod_r <= PROD_W'(pop_data.low_mag) * PROD_W'(DIV_RECIP);
      s1_col_r     <= pop_data.column;
      s1_last_r    <= pop_data.last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_upper_r <= up_q;
      out_lower_r <= LOWER_W'(0) - LOWER_W'(lo_q);
      out_col_r   <= s1_col_r;
      out_last_r  <= s1_last_r;
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= pop_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign upper_peak   = out_upper_r;
  assign lower_peak   = out_lower_r;
  assign column_index = out_col_r;
  assign last_column  = out_last_r;

endmodule

### design/waveform_minmax_decimator_top.sv
// ----------------------------------------------------------------------------
// waveform_minmax_decimator_top
// Reduces a signed 16-bit sample stream to a min/max display envelope.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one sample per beat, tdata = sample_value, tuser = frame_start.
//   out_* : one beat per finished column; tdata holds upper_peak, lower_peak
//           and column_index, tlast marks the final column of the frame.
//   cfg_* : APB register samples_per_column at byte address 0 (reset 1).
//   Throughput is one sample per cycle; the peak tracker in the front part
//   takes a sample every cycle as long as the column queue has room.
//   The result of the beat that ends a column passes through the queue, the
//   reciprocal multiply and the output register on its way to out_*.
//   When the receiver stalls the result holds in the output register, the
//   multiply stage and the four-entry queue fill behind it, and in_tready
//   falls only once the queue is full.
//   After reset samples build column zero even without frame_start; once the
//   last column is out, samples are dropped until one carries frame_start.
//   No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module waveform_minmax_decimator_top #(
  parameter int COLUMNS  = 600,
  parameter int SCAN_CAP = 200
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_value
  input  logic        in_tuser,   // [0] frame_start
  // column results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [6:0] upper_peak, [14:7] lower_peak,
                                  // [24:15] column_index, rest zero
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import wmd_pkg::*;

  localparam logic [SPC_W-1:0] SCAN_CAP_V = SPC_W'(SCAN_CAP);

  logic [SPC_W-1:0]  spc_r, spc_nxt;
  logic [SPC_W-1:0]  span_r, span_nxt;
  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic              cfg_wr;

  logic              push_valid, push_ready, pop_valid, pop_ready;
  col_rec_t          push_data, pop_data;
  logic [UPPER_W-1:0] upper_peak;
  logic [LOWER_W-1:0] lower_peak;
  logic [COL_W-1:0]   column_index;

  // register write and derived column lengths
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_SPC);

  always_comb begin
    spc_nxt  = cfg_pwdata[SPC_W-1:0];
    span_nxt = (spc_nxt == '0) ? SPC_W'(1) : spc_nxt;
    scan_nxt = (span_nxt < SCAN_CAP_V) ? span_nxt[SCAN_W-1:0]
                                       : SCAN_CAP_V[SCAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r  <= SPC_W'(1);
      span_r <= SPC_W'(1);
      scan_r <= SCAN_W'(1);
    end else if (cfg_wr) begin
      spc_r  <= spc_nxt;
      span_r <= span_nxt;
      scan_r <= scan_nxt;
    end
  end

  // register read
  assign cfg_prdata = (cfg_paddr[2] == REG_SPC) ? {8'b0, spc_r} : 32'b0;

  wmd_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .sample      (in_tdata),
    .frame_start (in_tuser),
    .span        (span_r),
    .scan        (scan_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  wmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  wmd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .upper_peak   (upper_peak),
    .lower_peak   (lower_peak),
    .column_index (column_index),
    .last_column  (out_tlast)
  );

  // pack result fields
  assign out_tdata = {7'b0, column_index, lower_peak, upper_peak};

endmodule

### sim/waveform_minmax_decimator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_minmax_decimator_top_test
// Self-checking bench for the min/max waveform decimator. Samples go in as
// stream beats and a local envelope tracker predicts every column result,
// which is checked field by field against the out_* beats. Directed tests
// cover the peak scaling edges, zero and lowered column lengths, frame
// restarts, the scan limit and the end of a frame. Random frames then run
// under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module waveform_minmax_decimator_top_test;
  import wmd_pkg::*;

  localparam int NUM_COLUMNS   = 600;
  localparam int SCAN_LIMIT    = 200;
  localparam int PEAK_DIV      = 300;
  localparam int RANDOM_BEATS  = 820;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [2:0] SPC_ADDR = 3'(4 * REG_SPC);

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [6:0]        upper;
    logic signed [7:0] lower;
    logic [9:0]        column;
    logic              last;
  } column_peaks_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] sample_value
  logic        in_tuser = 1'b0; // [0] frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [6:0] upper_peak, [14:7] lower_peak,
                                // [24:15] column_index, rest zero
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // envelope tracker state
  logic [SPC_W-1:0] col_len;
  int unsigned      col_fill;
  int unsigned      col_number;
  int               peak_hi;
  int               peak_lo;
  bit               frame_finished;

  column_peaks_t predicted_columns[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            sender_idle_pct = 0;
  int            receiver_stall_pct = 0;

  waveform_minmax_decimator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // column result checker
  always @(posedge clk) begin
    column_peaks_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_columns.size() == 0) begin
        $error("column result with none predicted: tdata %h", out_tdata);
        mismatch_count++;
      end else begin
        want = predicted_columns.pop_front();
        if (out_tdata[6:0] !== want.upper) begin
          $error("upper_peak: expected %0d, got %0d", want.upper, out_tdata[6:0]);
          mismatch_count++;
        end
        if (out_tdata[14:7] !== want.lower) begin
          $error("lower_peak: expected %0d, got %0d", want.lower,
                 $signed(out_tdata[14:7]));
          mismatch_count++;
        end
        if (out_tdata[24:15] !== want.column) begin
          $error("column_index: expected %0d, got %0d", want.column, out_tdata[24:15]);
          mismatch_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last_column: expected %0d, got %0d", want.last, out_tlast);
          mismatch_count++;
        end
        if (out_tdata[31:25] !== 7'd0) begin
          $error("tdata padding: expected 0, got %h", out_tdata[31:25]);
          mismatch_count++;
        end
      end
    end
  end

  // envelope tracker, returns 1 when the sample is dropped
  function automatic bit track_sample(logic signed [15:0] value, logic start);
    int unsigned   span;
    int unsigned   scan;
    column_peaks_t peaks;
    span = (col_len == 0) ? 1 : col_len;
    scan = (span < SCAN_LIMIT) ? span : SCAN_LIMIT;
    if (start) begin
      col_number     = 0;
      frame_finished = 1'b0;
      col_fill       = 0;
      peak_hi        = 0;
      peak_lo        = 0;
    end else if (frame_finished) begin
      return 1'b1;
    end
    if (col_fill < scan) begin
      if (int'(value) > peak_hi) peak_hi = value;
      else if (int'(value) < peak_lo) peak_lo = value;
    end
    col_fill++;
    if (col_fill < span) return 1'b0;
    peaks.upper  = 7'(peak_hi / PEAK_DIV);
    peaks.lower  = 8'(peak_lo / PEAK_DIV);
    peaks.column = 10'(col_number);
    peaks.last   = (col_number + 1 >= NUM_COLUMNS);
    predicted_columns.push_back(peaks);
    col_fill = 0;
    peak_hi  = 0;
    peak_lo  = 0;
    if (col_number + 1 >= NUM_COLUMNS) begin
      frame_finished = 1'b1;
      col_number     = 0;
    end else begin
      col_number++;
    end
    return 1'b0;
  endfunction

  // one sample beat, with random sender gaps in front
  task automatic push_sample(input logic signed [15:0] value, input logic start,
                             output bit dropped);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    dropped = track_sample(value, start);
  endtask

  // stop sending and let every predicted column come out
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (predicted_columns.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write then read-back over the config port
  task automatic set_column_length(input logic [SPC_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= SPC_ADDR;
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    col_len = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== 32'(value)) begin
      $error("samples_per_column: expected %0d, got %0d", value, cfg_prdata);
      mismatch_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(15))
      0: return 16'sd32767;
      1: return -16'sd32768;
      2: return 16'sd0;
      3: return 16'($urandom_range(1) ? 1 : -1) * 16'($urandom_range(298, 602));
      4: return 16'($signed($urandom_range(800)) - 400);
      default: return r[15:0];
    endcase
  endfunction

  function automatic logic [SPC_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return SPC_W'(1);
    if (roll < 65) return SPC_W'($urandom_range(2, 4));
    if (roll < 80) return SPC_W'($urandom_range(5, 20));
    return SPC_W'($urandom_range(195, 230));
  endfunction

  function automatic void set_idle_mode(idle_mode_t mode);
    sender_idle_pct    = (mode == IDLE_SENDER) ? 76 : (mode == IDLE_BOTH) ? 20 : 0;
    receiver_stall_pct = (mode == IDLE_RECEIVER) ? 76 : (mode == IDLE_BOTH) ? 20 : 0;
  endfunction

  // peak scaling edges straight after reset, column length 1, no frame start
  task automatic test_reset_columns();
    logic signed [15:0] edges[12];
    bit dropped;
    edges = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd299, 16'sd300, -16'sd299,
              -16'sd300, 16'sd301, -16'sd301, 16'sd32766, -16'sd1, 16'sd1};
    foreach (edges[i]) push_sample(edges[i], 1'b0, dropped);
    settle_block();
  endtask

  // a column length of zero behaves as one
  task automatic test_zero_length();
    bit dropped;
    set_column_length('0);
    push_sample(-16'sd12000, 1'b1, dropped);
    push_sample(16'sd9000, 1'b0, dropped);
    settle_block();
  endtask

  // frame start part way through a column throws the partial column away
  task automatic test_frame_restart();
    bit dropped;
    set_column_length(SPC_W'(4));
    push_sample(16'sd30000, 1'b1, dropped);
    push_sample(-16'sd30000, 1'b0, dropped);
    push_sample(16'sd700, 1'b1, dropped);
    for (int i = 0; i < 3; i++) push_sample(-16'sd650, 1'b0, dropped);
    settle_block();
  endtask

  // longest column, then length lowered below the fill so the next beat ends it
  task automatic test_lowered_length();
    bit dropped;
    set_column_length({SPC_W{1'b1}});
    push_sample(16'sd1234, 1'b1, dropped);
    for (int i = 0; i < 4; i++) push_sample(-16'sd4321, 1'b0, dropped);
    settle_block();
    set_column_length(SPC_W'(3));
    push_sample(16'sd20000, 1'b0, dropped);
    settle_block();
  endtask

  // peaks beyond the scan limit of a column are not seen
  task automatic test_scan_limit();
    bit dropped;
    set_column_length(SPC_W'(SCAN_LIMIT + 1));
    for (int i = 0; i <= SCAN_LIMIT; i++) begin
      if (i == SCAN_LIMIT) push_sample(16'sd32767, 1'b0, dropped);
      else if (i == SCAN_LIMIT - 1) push_sample(-16'sd32768, 1'b0, dropped);
      else push_sample(16'($urandom_range(1000)), i == 0, dropped);
    end
    settle_block();
  endtask

  // a whole frame, the dropped beats after it and a fresh frame
  task automatic test_frame_end();
    bit dropped;
    set_column_length(SPC_W'(1));
    push_sample(pick_sample(), 1'b1, dropped);
    for (int i = 1; i < NUM_COLUMNS; i++) push_sample(pick_sample(), 1'b0, dropped);
    for (int i = 0; i < 3; i++) push_sample(pick_sample(), 1'b0, dropped);
    push_sample(pick_sample(), 1'b1, dropped);
    settle_block();
  endtask

  // random frames in chunks, column length changed between chunks
  task automatic test_random_frames(input idle_mode_t mode, input int beats);
    int  taken;
    int  chunk;
    bit  dropped;
    logic start;
    taken = 0;
    set_idle_mode(mode);
    while (taken < beats) begin
      settle_block();
      set_column_length(pick_length());
      chunk = $urandom_range(60, 150);
      for (int i = 0; i < chunk; i++) begin
        start = frame_finished ? ($urandom_range(9) == 0) : ($urandom_range(1499) == 0);
        push_sample(pick_sample(), start, dropped);
        if (!dropped) taken++;
      end
    end
    settle_block();
  endtask

  initial begin
    col_len        = SPC_W'(1);
    col_fill       = 0;
    col_number     = 0;
    peak_hi        = 0;
    peak_lo        = 0;
    frame_finished = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idle_mode(IDLE_NONE);
    test_reset_columns();
    test_zero_length();
    test_frame_restart();
    test_lowered_length();
    set_idle_mode(IDLE_BOTH);
    test_scan_limit();
    test_frame_end();

    test_random_frames(IDLE_NONE, RANDOM_BEATS / 4);
    test_random_frames(IDLE_SENDER, RANDOM_BEATS / 4);
    test_random_frames(IDLE_RECEIVER, RANDOM_BEATS / 4);
    test_random_frames(IDLE_BOTH, RANDOM_BEATS / 4);

    settle_block();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
design/wmd_pkg.sv
design/wmd_front.sv
design/wmd_queue.sv
design/wmd_back.sv
design/waveform_minmax_decimator_top.sv
sim/waveform_minmax_decimator_top_test.sv
